>>> design/quaternion_vector_rotator_unit_macros.svh
// Assertion macros shared by the checker of the quaternion rotator.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef QUATERNION_VECTOR_ROTATOR_UNIT_MACROS_SVH
`define QUATERNION_VECTOR_ROTATOR_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define QVR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Plain condition checked at every rising clock edge outside reset.
`define QVR_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

>>> design/qvr_pkg.sv
// Shared widths, register codes and pipeline control type of the quaternion rotator.
// Used by the top level, the row datapath and the checker; depends on nothing.
`default_nettype none

package qvr_pkg;

	// Field widths and fixed-point formats.
	localparam int VEC_W  = 32;
	localparam int QUAT_W = 16;
	localparam int QFRAC  = QUAT_W - 2;
	localparam int PFRAC  = 2 * QFRAC;

	// Datapath widths: quaternion product, matrix entry, entry times vector, row sum.
	localparam int PROD_W = 2 * QUAT_W;
	localparam int ENT_W  = PROD_W + 1;
	localparam int MUL_W  = ENT_W + VEC_W;
	localparam int ACC_W  = MUL_W + 4;
	localparam int RND_W  = ACC_W - PFRAC;

	// Rounding offset: one half of the last kept bit.
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (PFRAC - 1);

	// Configuration register indexes.
	localparam logic [1:0] REG_QUAT_W = 2'd0;
	localparam logic [1:0] REG_QUAT_X = 2'd1;
	localparam logic [1:0] REG_QUAT_Y = 2'd2;
	localparam logic [1:0] REG_QUAT_Z = 2'd3;

	// Reset value of the scalar part: 1.0 in Q2.14.
	localparam logic [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1) << QFRAC;

	// Load enables of the back stages, handed to each row.
	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} qvr_ctrl_t;

endpackage

`default_nettype wire

>>> design/qvr_row.sv
// One output component: three entry-by-vector products, sum, rounding, saturation.
// Depends on qvr_pkg; stage enables come from the top level's flow control.
`default_nettype none

module qvr_row (
	input  wire logic                                 clk,
	input  wire qvr_pkg::qvr_ctrl_t                   ctrl,
	input  wire logic signed [qvr_pkg::ENT_W-1:0]     m0,
	input  wire logic signed [qvr_pkg::ENT_W-1:0]     m1,
	input  wire logic signed [qvr_pkg::ENT_W-1:0]     m2,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]     v0,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]     v1,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]     v2,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]     vi,
	output logic             [qvr_pkg::VEC_W-1:0]     res,
	output logic                                      ovf
);

	localparam int MUL_W = qvr_pkg::MUL_W;
	localparam int ACC_W = qvr_pkg::ACC_W;
	localparam int VEC_W = qvr_pkg::VEC_W;
	localparam int RND_W = qvr_pkg::RND_W;
	localparam int PFRAC = qvr_pkg::PFRAC;

	logic signed [MUL_W-1:0] p0_s3, p1_s3, p2_s3;
	logic signed [VEC_W-1:0] vi_s3;
	logic        [ACC_W-1:0] sum, vi_ext, acc;
	logic        [RND_W-1:0] rnd_s4;
	logic        [RND_W-VEC_W:0] hi_bits;
	logic                    in_range;

	// Stage 3: one full-precision multiply per matrix column.
	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			p0_s3 <= m0 * v0;
			p1_s3 <= m1 * v1;
			p2_s3 <= m2 * v2;
			vi_s3 <= vi;
		end
	end

	// Stage 4: double the row sum, remove the diagonal offset, round to nearest.
	always_comb begin
		sum = {{(ACC_W-MUL_W){p0_s3[MUL_W-1]}}, p0_s3}
			+ {{(ACC_W-MUL_W){p1_s3[MUL_W-1]}}, p1_s3}
			+ {{(ACC_W-MUL_W){p2_s3[MUL_W-1]}}, p2_s3};
		vi_ext = {{(ACC_W-VEC_W){vi_s3[VEC_W-1]}}, vi_s3};
		acc = (sum << 1) - (vi_ext << PFRAC) + qvr_pkg::RND_HALF;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s4) begin
			rnd_s4 <= acc[ACC_W-1:PFRAC];
		end
	end

	// Stage 5: clamp to the output range when the upper bits are not a sign extension.
	always_comb begin
		hi_bits  = rnd_s4[RND_W-1:VEC_W-1];
		in_range = (&hi_bits) || !(|hi_bits);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s5) begin
			ovf <= !in_range;
			if (in_range) begin
				res <= rnd_s4[VEC_W-1:0];
			end else if (rnd_s4[RND_W-1]) begin
				res <= {1'b1, {(VEC_W-1){1'b0}}};
			end else begin
				res <= {1'b0, {(VEC_W-1){1'b1}}};
			end
		end
	end

endmodule

`default_nettype wire

>>> design/quaternion_vector_rotator_unit.sv
// Quaternion vector rotator, top level: configuration registers, flow control,
// quaternion products and matrix build. Depends on qvr_pkg and qvr_row.
//
// Usage:
// - Configuration: cfg_we with cfg_index 0..3 writes quat_w, quat_x, quat_y, quat_z
//   (signed Q2.14) at the rising edge. Write only while no transaction is in flight.
// - Input channel: in_valid/in_ready carries to_local and vec_x/y/z (signed Q16.16).
//   to_local = 0 rotates with A, 1 with A transposed.
// - Output channel: out_valid/out_ready carries out_x/y/z (Q16.16, saturated) and
//   overflow, set when any component was clamped.
// - One transaction per cycle is accepted while the output is taken, through the
//   five-stage pipeline (quaternion products, matrix entries, 33x32 multiplies,
//   row sum, clamp).
// - When the receiver stalls, each stage holds while its successor is full; empty
//   stages keep filling, so up to five transactions are taken before in_ready falls.
// - Reset clears all stage valid bits and loads the identity quaternion.
`default_nettype none

module quaternion_vector_rotator_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [qvr_pkg::QUAT_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              to_local,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]  vec_x,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]  vec_y,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]  vec_z,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [qvr_pkg::VEC_W-1:0]       out_x,
	output logic signed [qvr_pkg::VEC_W-1:0]       out_y,
	output logic signed [qvr_pkg::VEC_W-1:0]       out_z,
	output logic                                   overflow
);

	localparam int QUAT_W = qvr_pkg::QUAT_W;
	localparam int VEC_W  = qvr_pkg::VEC_W;
	localparam int PROD_W = qvr_pkg::PROD_W;
	localparam int ENT_W  = qvr_pkg::ENT_W;

	logic signed [QUAT_W-1:0] qw_q, qx_q, qy_q, qz_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;
	qvr_pkg::qvr_ctrl_t ctrl;

	logic signed [PROD_W-1:0] p00_s1, p11_s1, p22_s1, p33_s1;
	logic signed [PROD_W-1:0] p12_s1, p13_s1, p23_s1, p01_s1, p02_s1, p03_s1;
	logic                     loc_s1;
	logic signed [VEC_W-1:0]  vec_s1 [3];

	logic signed [ENT_W-1:0]  e00, e11, e22, e33, e12, e13, e23, c01, c02, c03;
	logic signed [ENT_W-1:0]  m_s2 [3][3];
	logic signed [VEC_W-1:0]  vec_s2 [3];

	logic [VEC_W-1:0] res [3];
	logic             ovf [3];

	// Configuration registers, identity rotation after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= qvr_pkg::QUAT_ONE;
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qvr_pkg::REG_QUAT_W: qw_q <= cfg_data;
				qvr_pkg::REG_QUAT_X: qx_q <= cfg_data;
				qvr_pkg::REG_QUAT_Y: qy_q <= cfg_data;
				qvr_pkg::REG_QUAT_Z: qz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flow control: a stage loads when it is empty or its successor moves on.
	always_comb begin
		adv5 = !v_s5 || out_ready;
		adv4 = !v_s4 || adv5;
		adv3 = !v_s3 || adv4;
		adv2 = !v_s2 || adv3;
		adv1 = !v_s1 || adv2;
		in_ready = adv1;
		ctrl.en_s3 = adv3;
		ctrl.en_s4 = adv4;
		ctrl.en_s5 = adv5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// Stage 1: the ten distinct quaternion products, captured with the vector.
	always_ff @(posedge clk) begin
		if (adv1) begin
			p00_s1 <= qw_q * qw_q;
			p11_s1 <= qx_q * qx_q;
			p22_s1 <= qy_q * qy_q;
			p33_s1 <= qz_q * qz_q;
			p12_s1 <= qx_q * qy_q;
			p13_s1 <= qx_q * qz_q;
			p23_s1 <= qy_q * qz_q;
			p01_s1 <= qw_q * qx_q;
			p02_s1 <= qw_q * qy_q;
			p03_s1 <= qw_q * qz_q;
			loc_s1 <= to_local;
			vec_s1[0] <= vec_x;
			vec_s1[1] <= vec_y;
			vec_s1[2] <= vec_z;
		end
	end

	// Stage 2: matrix entries (halved, offset excluded). Transposing the matrix
	// only flips the sign of the terms that carry the scalar part.
	always_comb begin
		e00 = {p00_s1[PROD_W-1], p00_s1};
		e11 = {p11_s1[PROD_W-1], p11_s1};
		e22 = {p22_s1[PROD_W-1], p22_s1};
		e33 = {p33_s1[PROD_W-1], p33_s1};
		e12 = {p12_s1[PROD_W-1], p12_s1};
		e13 = {p13_s1[PROD_W-1], p13_s1};
		e23 = {p23_s1[PROD_W-1], p23_s1};
		c01 = {p01_s1[PROD_W-1], p01_s1};
		c02 = {p02_s1[PROD_W-1], p02_s1};
		c03 = {p03_s1[PROD_W-1], p03_s1};
		if (loc_s1) begin
			c01 = -c01;
			c02 = -c02;
			c03 = -c03;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			m_s2[0][0] <= e00 + e11;
			m_s2[0][1] <= e12 - c03;
			m_s2[0][2] <= e13 + c02;
			m_s2[1][0] <= e12 + c03;
			m_s2[1][1] <= e00 + e22;
			m_s2[1][2] <= e23 - c01;
			m_s2[2][0] <= e13 - c02;
			m_s2[2][1] <= e23 + c01;
			m_s2[2][2] <= e00 + e33;
			vec_s2 <= vec_s1;
		end
	end

	// Stages 3 to 5: one datapath row per output component.
	for (genvar i = 0; i < 3; i++) begin : g_row
		qvr_row u_row (
			.clk  (clk),
			.ctrl (ctrl),
			.m0   (m_s2[i][0]),
			.m1   (m_s2[i][1]),
			.m2   (m_s2[i][2]),
			.v0   (vec_s2[0]),
			.v1   (vec_s2[1]),
			.v2   (vec_s2[2]),
			.vi   (vec_s2[i]),
			.res  (res[i]),
			.ovf  (ovf[i])
		);
	end

	// Output channel straight from the last stage.
	always_comb begin
		out_valid = v_s5;
		out_x     = res[0];
		out_y     = res[1];
		out_z     = res[2];
		overflow  = ovf[0] || ovf[1] || ovf[2];
	end

endmodule

`default_nettype wire

>>> design/qvr_checker.sv
// Port-level checker for the quaternion rotator, bound to the top level.
// Depends on qvr_pkg and the shared assertion macros header.
`default_nettype none

`include "quaternion_vector_rotator_unit_macros.svh"

module qvr_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [qvr_pkg::VEC_W-1:0]  out_x,
	input wire logic signed [qvr_pkg::VEC_W-1:0]  out_y,
	input wire logic signed [qvr_pkg::VEC_W-1:0]  out_z,
	input wire logic                              overflow
);

	localparam int VEC_W = qvr_pkg::VEC_W;
	localparam logic [VEC_W-1:0] SAT_MAX = {1'b0, {(VEC_W-1){1'b1}}};
	localparam logic [VEC_W-1:0] SAT_MIN = {1'b1, {(VEC_W-1){1'b0}}};

	logic any_clamped;

	// At least one component sits on a bound of the output range.
	always_comb begin
		any_clamped = (out_x == SAT_MAX) || (out_x == SAT_MIN)
			|| (out_y == SAT_MAX) || (out_y == SAT_MIN)
			|| (out_z == SAT_MAX) || (out_z == SAT_MIN);
	end

	// A stalled result stays offered.
	`QVR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	// A flagged overflow shows at least one clamped component.
	`QVR_ASSERT(a_ovf_sat, out_valid && overflow |-> any_clamped, "overflow without a clamped component")

	// A result that appears after an empty output matches an earlier input transaction.
	`QVR_ASSERT(a_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 5), "result without matching input transaction")

	// With the output stage empty the whole pipeline can move, so input is taken.
	`QVR_ASSERT_NOW(a_ready_free, !out_valid -> in_ready, "input refused with empty output stage")

endmodule

bind quaternion_vector_rotator_unit qvr_checker u_qvr_checker (.*);

`default_nettype wire
